/* hw/rtl/lfid_pkg.sv */
`default_nettype none

package lfid_pkg;

    localparam int ID_W      = 6;
    localparam int LIM_W     = 7;
    localparam int CNT_W     = 7;
    localparam int CELL_W    = 16;
    localparam int CELL_LOG  = 4;
    localparam int SLOTS_DEF = 64;
    localparam int DATA_W    = 16;
    localparam logic [LIM_W-1:0] LIMIT_RST = LIM_W'(64);

    typedef enum logic [1:0] {
        ACT_GET     = 2'd0,
        ACT_CHECK   = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_NOP     = 2'd3
    } t_act;

    // request and partial result handed from cell to cell
    typedef struct packed {
        logic              valid;
        t_act              act;
        logic [ID_W-1:0]   id;
        logic [LIM_W-1:0]  lim;
        logic              found;
        logic [ID_W-1:0]   kout;
        logic              free;
        logic              dec;
    } t_carry;

endpackage

`default_nettype wire

/* hw/rtl/lowest_free_id_allocator.sv */
// lowest free id allocator
// requests enter on the s_axis channel: tuser holds the action (get, check,
// release, no-op), tdata the id to check or release. every request gives
// exactly one result on the m_axis channel: granted, the id handed out,
// the free flag of a check and the count of ids in use afterwards.
// the used bitmap lives in a row of 16-bit cells; a request walks down the
// row one cell per cycle, each cell finding its lowest free bit or acting
// on the id it owns; a result passes the registers of all cells in turn,
// then the output register (via the holding register under a stall), and
// shows on m_axis. a new request is taken only once the last result has
// left the row. the user writes the id limit through i_cfg_we / i_cfg_wdata
// only while idle; the block itself does not enforce this. reset clears the
// bitmap and the count and sets the limit to 64.
// a stalled receiver holds the result in the output register; one more
// result can finish into a holding register, after which s_axis_tready
// stays low until the receiver takes a result.
`default_nettype none

module lowest_free_id_allocator
    import lfid_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire [LIM_W-1:0]   i_cfg_wdata,
    input  wire               s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire [7:0]         s_axis_tdata,   // id_in[5:0], zero[7:6]
    input  wire [1:0]         s_axis_tuser,   // action[1:0]
    output logic              m_axis_tvalid,
    input  wire               m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata    // granted, id_out, is_free, used_count, zero
);

    localparam int LIM_MAX = (SLOTS < 64) ? SLOTS : 64;
    localparam int NCELL   = (LIM_MAX + CELL_W - 1) / CELL_W;

    t_carry             chain [NCELL+1];
    logic [LIM_W-1:0]   r_limit;
    logic [LIM_W-1:0]   eff_lim;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_busy;
    logic               r_pend_valid;
    logic [DATA_W-1:0]  r_pend;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out;
    logic               s_fire;
    logic               out_free;
    logic               res_end;
    logic [DATA_W-1:0]  res_word;

    assign eff_lim  = (r_limit > LIM_W'(LIM_MAX)) ? LIM_W'(LIM_MAX) : r_limit;
    assign out_free = !r_out_valid || m_axis_tready;
    assign res_end  = chain[NCELL].valid;
    assign s_axis_tready = !r_busy || ((res_end || r_pend_valid) && out_free);
    assign s_fire   = s_axis_tvalid && s_axis_tready;

    always_comb begin
        chain[0].valid = s_fire;
        chain[0].act   = t_act'(s_axis_tuser);
        chain[0].id    = s_axis_tdata[ID_W-1:0];
        chain[0].lim   = eff_lim;
        chain[0].found = 1'b0;
        chain[0].kout  = '0;
        chain[0].free  = 1'b0;
        chain[0].dec   = 1'b0;
    end

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        lfid_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_carry (chain[g]),
            .o_carry (chain[g+1])
        );
    end

    always_comb begin
        n_count = r_count;
        if (chain[NCELL].found) begin
            n_count = r_count + CNT_W'(1);
        end else if (chain[NCELL].dec) begin
            n_count = r_count - CNT_W'(1);
        end
        res_word = {1'b0, n_count,
                    chain[NCELL].free && (chain[NCELL].act == ACT_CHECK),
                    chain[NCELL].found ? chain[NCELL].kout : ID_W'(0),
                    chain[NCELL].found};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit      <= LIMIT_RST;
            r_count      <= '0;
            r_busy       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (res_end) begin
                r_count <= n_count;
            end
            if (s_fire) begin
                r_busy <= 1'b1;
            end else if ((res_end || r_pend_valid) && out_free) begin
                r_busy <= 1'b0;
            end
            if (r_pend_valid && out_free) begin
                r_out_valid  <= 1'b1;
                r_out        <= r_pend;
                r_pend_valid <= 1'b0;
            end else if (res_end && out_free) begin
                r_out_valid <= 1'b1;
                r_out       <= res_word;
            end else if (res_end) begin
                r_pend_valid <= 1'b1;
                r_pend       <= res_word;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

`default_nettype wire

/* hw/rtl/lfid_cell.sv */
`default_nettype none

module lfid_cell
    import lfid_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  t_carry i_carry,
    output t_carry o_carry
);

    localparam int BASE = IDX * CELL_W;

    logic [CELL_W-1:0]   r_map;
    logic [CELL_W-1:0]   n_map;
    logic                r_valid;
    t_carry              r_carry;
    t_carry              n_carry;
    logic [CELL_W-1:0]   mask;
    logic [CELL_W-1:0]   avail;
    logic [CELL_LOG-1:0] sel;
    logic [CELL_LOG-1:0] jid;
    logic                owned;

    always_comb begin
        for (int j = 0; j < CELL_W; j++) begin
            mask[j] = LIM_W'(BASE + j) < i_carry.lim;
        end
        avail = ~r_map & mask;
        sel   = '0;
        for (int j = CELL_W - 1; j >= 0; j--) begin
            if (avail[j]) begin
                sel = CELL_LOG'(j);
            end
        end
        jid   = i_carry.id[CELL_LOG-1:0];
        owned = i_carry.id[ID_W-1:CELL_LOG] == (ID_W-CELL_LOG)'(IDX);

        n_map   = r_map;
        n_carry = i_carry;
        if (i_carry.valid) begin
            case (i_carry.act)
                ACT_GET: begin
                    if (!i_carry.found && (|avail)) begin
                        n_map[sel]    = 1'b1;
                        n_carry.found = 1'b1;
                        n_carry.kout  = ID_W'(BASE) + ID_W'(sel);
                    end
                end
                ACT_CHECK: begin
                    if (owned && mask[jid] && !r_map[jid]) begin
                        n_carry.free = 1'b1;
                    end
                end
                ACT_RELEASE: begin
                    if (owned && mask[jid] && r_map[jid]) begin
                        n_map[jid]  = 1'b0;
                        n_carry.dec = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_map   <= n_map;
            r_valid <= i_carry.valid;
        end
        r_carry <= n_carry;
    end

    always_comb begin
        o_carry       = r_carry;
        o_carry.valid = r_valid;
    end

endmodule

`default_nettype wire

/* hw/rtl/lfid_chk.sv */
`default_nettype none

module lfid_chk
    import lfid_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              m_axis_tvalid,
    input wire              m_axis_tready,
    input wire [DATA_W-1:0] m_axis_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[7]))
        else $error("grant and free flag together");

    a_idzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[6:1] == '0)
        else $error("id out without grant");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> int'(m_axis_tdata[14:8]) <= SLOTS)
        else $error("used count above slot count");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind lowest_free_id_allocator lfid_chk #(
    .SLOTS (SLOTS)
) u_lfid_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
